FILE: hdl/tilt_fall_detector_assert.svh
// Assertion macros for the checker file of the tilt fall detector.
`ifndef TILT_FALL_DETECTOR_ASSERT_SVH
`define TILT_FALL_DETECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold at a later cycle than the antecedent.
`define TFD_ASSERT_TWO(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error(msg);

`endif

FILE: hdl/tfd_pkg.sv
package tfd_pkg;

   localparam int CountBits   = 8;
   localparam int LimitBits   = 8;
   localparam int CmpBits     = (CountBits > LimitBits) ? CountBits : LimitBits;
   localparam int AngleBits   = 13;
   localparam int WideBits    = 14;
   localparam int MagBits     = 12;
   localparam int StatusBits  = 3;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;

   typedef enum logic [StatusBits-1:0] {
      STATUS_STABLE   = 3'd0,
      STATUS_UNSTABLE = 3'd1,
      STATUS_FRONT    = 3'd2,
      STATUS_BACK     = 3'd3,
      STATUS_LEFT     = 3'd4,
      STATUS_RIGHT    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_FWD_LOW   = 3'd0,
      REG_FWD_HIGH  = 3'd1,
      REG_SIDE_LIM  = 3'd2,
      REG_FALL_LIM  = 3'd3,
      REG_COUNT_LIM = 3'd4
   } reg_index_type;

   localparam logic signed [AngleBits-1:0] FwdLowReset  = -13'sd80;
   localparam logic signed [AngleBits-1:0] FwdHighReset = 13'sd400;
   localparam logic [MagBits-1:0]          SideLimReset = 12'd448;
   localparam logic [MagBits-1:0]          FallLimReset = 12'd960;
   localparam logic [LimitBits-1:0]        CountLimReset = 8'd10;

   typedef struct packed {
      logic unsafe;
      logic front_past;
      logic back_past;
      logic left_past;
      logic right_past;
   } class_type;

   typedef struct packed {
      logic signed [AngleBits-1:0] fwd_low;
      logic signed [AngleBits-1:0] fwd_high;
      logic [MagBits-1:0]          side_lim;
      logic [MagBits-1:0]          fall_lim;
   } limits_type;

endpackage

FILE: hdl/tfd_front.sv
module tfd_front (
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tfd_pkg::AngleBits-1:0]   req_angle_a,
   input  logic signed [tfd_pkg::AngleBits-1:0]   req_angle_b,
   input  tfd_pkg::limits_type                    limits,
   input  logic                                   queue_full,
   output logic                                   push,
   output tfd_pkg::class_type                     push_class
);

   logic signed [tfd_pkg::WideBits-1:0] forward;
   logic signed [tfd_pkg::WideBits-1:0] side;
   logic signed [tfd_pkg::WideBits-1:0] abs_side;
   logic signed [tfd_pkg::WideBits-1:0] fall;
   logic signed [tfd_pkg::WideBits-1:0] neg_fall;
   logic signed [tfd_pkg::WideBits-1:0] low_lim;
   logic signed [tfd_pkg::WideBits-1:0] high_lim;
   logic signed [tfd_pkg::WideBits-1:0] side_lim;

   always_comb begin
      forward  = -tfd_pkg::WideBits'(req_angle_b);
      side     = tfd_pkg::WideBits'(req_angle_a);
      abs_side = side[tfd_pkg::WideBits-1] ? -side : side;
      fall     = $signed({2'b00, limits.fall_lim});
      neg_fall = -fall;
      low_lim  = tfd_pkg::WideBits'(limits.fwd_low);
      high_lim = tfd_pkg::WideBits'(limits.fwd_high);
      side_lim = $signed({2'b00, limits.side_lim});

      push_class.unsafe     = (forward < low_lim) || (forward > high_lim) ||
                              (abs_side > side_lim);
      push_class.front_past = forward > fall;
      push_class.back_past  = forward < neg_fall;
      push_class.right_past = side > fall;
      push_class.left_past  = side < neg_fall;
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

FILE: hdl/tfd_queue.sv
module tfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tfd_pkg::class_type push_class,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output tfd_pkg::class_type pop_class
);

   tfd_pkg::class_type slot_ff [tfd_pkg::QueueDepth];
   logic [tfd_pkg::QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tfd_pkg::QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tfd_pkg::QueueCntBits-1:0] count_ff, count_in;

   assign full      = count_ff == tfd_pkg::QueueCntBits'(tfd_pkg::QueueDepth);
   assign not_empty = count_ff != '0;
   assign pop_class = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tfd_pkg::QueuePtrBits'(tfd_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tfd_pkg::QueuePtrBits'(tfd_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + tfd_pkg::QueueCntBits'(push) - tfd_pkg::QueueCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule

FILE: hdl/tfd_back.sv
module tfd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               not_empty,
   input  tfd_pkg::class_type                 pop_class,
   output logic                               pop,
   input  logic [tfd_pkg::LimitBits-1:0]      count_limit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tfd_pkg::StatusBits-1:0]     rsp_status
);

   localparam logic [tfd_pkg::CountBits-1:0] CountMax = '1;

   logic [tfd_pkg::CountBits-1:0] front_count_ff, front_count_in;
   logic [tfd_pkg::CountBits-1:0] back_count_ff, back_count_in;
   logic [tfd_pkg::CountBits-1:0] left_count_ff, left_count_in;
   logic [tfd_pkg::CountBits-1:0] right_count_ff, right_count_in;
   logic [tfd_pkg::CountBits-1:0] stable_count_ff, stable_count_in;
   tfd_pkg::status_type           status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tfd_pkg::CmpBits-1:0]   limit_ext;

   function automatic logic [tfd_pkg::CountBits-1:0] bump(
      input logic [tfd_pkg::CountBits-1:0] c
   );
      return (c == CountMax) ? c : c + 1'b1;
   endfunction

   function automatic logic over(
      input logic [tfd_pkg::CountBits-1:0] c,
      input logic [tfd_pkg::CmpBits-1:0]   lim
   );
      return tfd_pkg::CmpBits'(c) > lim;
   endfunction

   assign pop       = not_empty && (!rsp_valid_ff || rsp_ready);
   assign limit_ext = tfd_pkg::CmpBits'(count_limit);

   always_comb begin
      front_count_in  = front_count_ff;
      back_count_in   = back_count_ff;
      left_count_in   = left_count_ff;
      right_count_in  = right_count_ff;
      stable_count_in = stable_count_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (pop) begin
         rsp_valid_in = 1'b1;
         if (pop_class.unsafe) begin
            stable_count_in = '0;
            front_count_in  = pop_class.front_past ? bump(front_count_ff) : '0;
            back_count_in   = pop_class.back_past  ? bump(back_count_ff)  : '0;
            left_count_in   = pop_class.left_past  ? bump(left_count_ff)  : '0;
            right_count_in  = pop_class.right_past ? bump(right_count_ff) : '0;
            if (pop_class.front_past || pop_class.back_past ||
                pop_class.left_past || pop_class.right_past) begin
               status_in = tfd_pkg::STATUS_UNSTABLE;
            end
         end else begin
            stable_count_in = bump(stable_count_ff);
            front_count_in  = '0;
            back_count_in   = '0;
            left_count_in   = '0;
            right_count_in  = '0;
         end

         if (over(front_count_in, limit_ext)) begin
            status_in = tfd_pkg::STATUS_FRONT;
         end else if (over(back_count_in, limit_ext)) begin
            status_in = tfd_pkg::STATUS_BACK;
         end else if (over(left_count_in, limit_ext)) begin
            status_in = tfd_pkg::STATUS_LEFT;
         end else if (over(right_count_in, limit_ext)) begin
            status_in = tfd_pkg::STATUS_RIGHT;
         end else if (over(stable_count_in, limit_ext)) begin
            status_in = tfd_pkg::STATUS_STABLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_count_ff  <= '0;
         back_count_ff   <= '0;
         left_count_ff   <= '0;
         right_count_ff  <= '0;
         stable_count_ff <= '0;
         status_ff       <= tfd_pkg::STATUS_STABLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         front_count_ff  <= front_count_in;
         back_count_ff   <= back_count_in;
         left_count_ff   <= left_count_in;
         right_count_ff  <= right_count_in;
         stable_count_ff <= stable_count_in;
         status_ff       <= status_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

endmodule

FILE: hdl/tilt_fall_detector.sv
// Tilt fall detector: each request carries one pair of filter angles in 1/16 degree; side tilt
// is angle_a and forward tilt is minus angle_b. Every request yields exactly one response with
// the status (stable, unstable, or a front, back, left or right fall). The block takes one
// request per clock cycle for as long as responses are taken. A response is offered once its
// request has passed through the two-entry queue between the classifying front and the counter
// stage and into the status register, which then holds the response until it is taken. While
// responses are held back, the queue holds up to two requests before the request side stalls.
// The five limit registers sit at byte addresses 0, 4, 8, 12 and 16 and should be written only
// while the block is idle.
module tilt_fall_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tfd_pkg::AngleBits-1:0]  req_angle_a,
   input  logic signed [tfd_pkg::AngleBits-1:0]  req_angle_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tfd_pkg::StatusBits-1:0]        rsp_status,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tfd_pkg::CsrAddrBits-1:0]       csr_paddr,
   input  logic [tfd_pkg::CsrDataBits-1:0]       csr_pwdata,
   output logic [tfd_pkg::CsrDataBits-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   tfd_pkg::limits_type           limits_ff, limits_in;
   logic [tfd_pkg::LimitBits-1:0] count_limit_ff, count_limit_in;
   logic                          csr_write;
   tfd_pkg::reg_index_type        csr_index;

   logic                          queue_full;
   logic                          queue_not_empty;
   logic                          push;
   logic                          pop;
   tfd_pkg::class_type            push_class;
   tfd_pkg::class_type            pop_class;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = tfd_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      limits_in      = limits_ff;
      count_limit_in = count_limit_ff;
      if (csr_write) begin
         case (csr_index)
            tfd_pkg::REG_FWD_LOW: begin
               limits_in.fwd_low = csr_pwdata[tfd_pkg::AngleBits-1:0];
            end
            tfd_pkg::REG_FWD_HIGH: begin
               limits_in.fwd_high = csr_pwdata[tfd_pkg::AngleBits-1:0];
            end
            tfd_pkg::REG_SIDE_LIM: begin
               limits_in.side_lim = csr_pwdata[tfd_pkg::MagBits-1:0];
            end
            tfd_pkg::REG_FALL_LIM: begin
               limits_in.fall_lim = csr_pwdata[tfd_pkg::MagBits-1:0];
            end
            tfd_pkg::REG_COUNT_LIM: begin
               count_limit_in = csr_pwdata[tfd_pkg::LimitBits-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tfd_pkg::REG_FWD_LOW: begin
            csr_prdata = tfd_pkg::CsrDataBits'(limits_ff.fwd_low);
         end
         tfd_pkg::REG_FWD_HIGH: begin
            csr_prdata = tfd_pkg::CsrDataBits'(limits_ff.fwd_high);
         end
         tfd_pkg::REG_SIDE_LIM: begin
            csr_prdata = tfd_pkg::CsrDataBits'(limits_ff.side_lim);
         end
         tfd_pkg::REG_FALL_LIM: begin
            csr_prdata = tfd_pkg::CsrDataBits'(limits_ff.fall_lim);
         end
         tfd_pkg::REG_COUNT_LIM: begin
            csr_prdata = tfd_pkg::CsrDataBits'(count_limit_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.fwd_low  <= tfd_pkg::FwdLowReset;
         limits_ff.fwd_high <= tfd_pkg::FwdHighReset;
         limits_ff.side_lim <= tfd_pkg::SideLimReset;
         limits_ff.fall_lim <= tfd_pkg::FallLimReset;
         count_limit_ff     <= tfd_pkg::CountLimReset;
      end else begin
         limits_ff      <= limits_in;
         count_limit_ff <= count_limit_in;
      end
   end

   tfd_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_angle_a (req_angle_a),
      .req_angle_b (req_angle_b),
      .limits      (limits_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_class  (push_class)
   );

   tfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_class (push_class),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop_class  (pop_class)
   );

   tfd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (queue_not_empty),
      .pop_class   (pop_class),
      .pop         (pop),
      .count_limit (count_limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status)
   );

endmodule

FILE: hdl/tfd_checker.sv
`include "tilt_fall_detector_assert.svh"

module tfd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [tfd_pkg::StatusBits-1:0]        rsp_status
);

   `TFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "response dropped or changed while stalled")

   `TFD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid straight after reset")

   `TFD_ASSERT_TWO(a_req_reaches_rsp, clock, reset, req_valid && req_ready, rsp_valid, "accepted request did not reach the response port in time")

   `TFD_ASSERT_SAME(a_stall_needs_rsp, clock, reset, !req_ready, rsp_valid, "request side stalled with no response pending")

endmodule

bind tilt_fall_detector tfd_checker u_tfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status)
);

FILE: tb/sv/tb_top.sv
module tb_top;

   localparam int CycleLimit  = 300000;
   localparam int RandomItems = 1450;
   localparam int CalmItems   = 200;
   localparam int PhaseItems  = 150;
   localparam int UnusedReg   = int'(tfd_pkg::REG_COUNT_LIM) + 1;

   typedef enum int {
      RUN_SAFE,
      RUN_FRONT,
      RUN_BACK,
      RUN_LEFT,
      RUN_RIGHT,
      RUN_EDGE,
      RUN_DIAGONAL,
      RUN_NOISE,
      RUN_BROKEN
   } run_kind_type;

   class tilt_scoreboard;
      logic signed [tfd_pkg::AngleBits-1:0] fwd_low;
      logic signed [tfd_pkg::AngleBits-1:0] fwd_high;
      logic [tfd_pkg::MagBits-1:0]          side_lim;
      logic [tfd_pkg::MagBits-1:0]          fall_lim;
      logic [tfd_pkg::LimitBits-1:0]        count_lim;
      logic [tfd_pkg::CountBits-1:0]        front_n, back_n, left_n, right_n, stable_n;
      tfd_pkg::status_type                  held;
      tfd_pkg::status_type                  pending[$];
      int                                   mismatches;

      function new();
         fwd_low = -13'sd80;
         fwd_high = 13'sd400;
         side_lim = 12'd448;
         fall_lim = 12'd960;
         count_lim = 8'd10;
         front_n = '0;
         back_n = '0;
         left_n = '0;
         right_n = '0;
         stable_n = '0;
         held = tfd_pkg::STATUS_STABLE;
         mismatches = 0;
      endfunction

      function void write_limit(int idx, logic [tfd_pkg::CsrDataBits-1:0] data);
         case (idx)
            tfd_pkg::REG_FWD_LOW:   fwd_low = data[tfd_pkg::AngleBits-1:0];
            tfd_pkg::REG_FWD_HIGH:  fwd_high = data[tfd_pkg::AngleBits-1:0];
            tfd_pkg::REG_SIDE_LIM:  side_lim = data[tfd_pkg::MagBits-1:0];
            tfd_pkg::REG_FALL_LIM:  fall_lim = data[tfd_pkg::MagBits-1:0];
            tfd_pkg::REG_COUNT_LIM: count_lim = data[tfd_pkg::LimitBits-1:0];
            default: ;
         endcase
      endfunction

      // Outside the safe window, a direction counter counts while its tilt is past the fall
      // limit, and any count marks the body as unstable.
      function logic [tfd_pkg::CountBits-1:0] advance(logic [tfd_pkg::CountBits-1:0] n,
                                                      bit past);
         if (!past) return '0;
         held = tfd_pkg::STATUS_UNSTABLE;
         return (&n) ? n : n + 1'b1;
      endfunction

      function void note_request(logic signed [tfd_pkg::AngleBits-1:0] a,
                                 logic signed [tfd_pkg::AngleBits-1:0] b);
         int side, fwd, mag, lo, hi, sl, fall;
         side = a;
         fwd = b;
         fwd = -fwd;
         mag = (side < 0) ? -side : side;
         lo = fwd_low;
         hi = fwd_high;
         sl = side_lim;
         fall = fall_lim;
         if (fwd < lo || fwd > hi || mag > sl) begin
            stable_n = '0;
            front_n = advance(front_n, fwd > fall);
            back_n = advance(back_n, fwd < -fall);
            right_n = advance(right_n, side > fall);
            left_n = advance(left_n, side < -fall);
         end else begin
            stable_n = (&stable_n) ? stable_n : stable_n + 1'b1;
            front_n = '0;
            back_n = '0;
            left_n = '0;
            right_n = '0;
         end
         if (front_n > count_lim) held = tfd_pkg::STATUS_FRONT;
         else if (back_n > count_lim) held = tfd_pkg::STATUS_BACK;
         else if (left_n > count_lim) held = tfd_pkg::STATUS_LEFT;
         else if (right_n > count_lim) held = tfd_pkg::STATUS_RIGHT;
         else if (stable_n > count_lim) held = tfd_pkg::STATUS_STABLE;
         pending.insert(pending.size(), held);
      endfunction

      function void check_status(logic [tfd_pkg::StatusBits-1:0] got);
         tfd_pkg::status_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d with no request outstanding", got);
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("status mismatch: expected %0d (%s), actual %0d", want, want.name(), got);
         end
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic signed [tfd_pkg::AngleBits-1:0]   req_angle_a;
   logic signed [tfd_pkg::AngleBits-1:0]   req_angle_b;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [tfd_pkg::StatusBits-1:0]         rsp_status;
   logic                                   csr_psel;
   logic                                   csr_penable;
   logic                                   csr_pwrite;
   logic [tfd_pkg::CsrAddrBits-1:0]        csr_paddr;
   logic [tfd_pkg::CsrDataBits-1:0]        csr_pwdata;
   logic [tfd_pkg::CsrDataBits-1:0]        csr_prdata;
   logic                                   csr_pready;

   tilt_scoreboard book;
   bit             idle_on;
   int             random_count;
   int             cycle_count;

   tilt_fall_detector uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_angle_a (req_angle_a),
      .req_angle_b (req_angle_b),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_status(rsp_status);
   end

   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(4) == 0) begin
            stall = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic int pick(int lo, int hi);
      if (hi <= lo) return lo;
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic logic signed [tfd_pkg::AngleBits-1:0] clip(int v);
      if (v < -4096) return tfd_pkg::AngleBits'(-4096);
      if (v > 4095) return 13'sd4095;
      return v[tfd_pkg::AngleBits-1:0];
   endfunction

   function automatic void make_angles(input run_kind_type kind,
                                       output logic signed [tfd_pkg::AngleBits-1:0] a,
                                       output logic signed [tfd_pkg::AngleBits-1:0] b);
      int lo, hi, sl, fall, fwd, side;
      lo = book.fwd_low;
      hi = book.fwd_high;
      sl = book.side_lim;
      fall = book.fall_lim;
      fwd = pick(lo, hi);
      side = pick(-sl, sl);
      case (kind)
         RUN_FRONT: fwd = pick(fall + 1, 4096);
         RUN_BACK:  fwd = pick(-4095, -fall - 1);
         RUN_LEFT:  side = pick(-4096, -fall - 1);
         RUN_RIGHT: side = pick(fall + 1, 4095);
         RUN_EDGE: begin
            case ($urandom_range(3))
               0: fwd = hi + pick(0, 8);
               1: fwd = lo - pick(0, 8);
               2: side = sl + pick(0, 8);
               default: side = -sl - pick(0, 8);
            endcase
         end
         RUN_DIAGONAL: begin
            fwd = $urandom_range(1) ? pick(fall + 1, 4096) : pick(-4095, -fall - 1);
            side = $urandom_range(1) ? pick(fall + 1, 4095) : pick(-4096, -fall - 1);
         end
         RUN_NOISE: begin
            fwd = pick(-4095, 4096);
            side = pick(-4096, 4095);
         end
         RUN_BROKEN: begin
            if ($urandom_range(1)) fwd = pick(fall + 1, 4096);
         end
         default: ;
      endcase
      a = clip(side);
      b = clip(-fwd);
   endfunction

   task automatic write_limit(input int idx, input logic [tfd_pkg::CsrDataBits-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= tfd_pkg::CsrAddrBits'(idx * 4);
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      book.write_limit(idx, data);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [tfd_pkg::CsrDataBits-1:0] lo,
                             input logic [tfd_pkg::CsrDataBits-1:0] hi,
                             input logic [tfd_pkg::CsrDataBits-1:0] side,
                             input logic [tfd_pkg::CsrDataBits-1:0] fall,
                             input logic [tfd_pkg::CsrDataBits-1:0] count);
      write_limit(tfd_pkg::REG_FWD_LOW, lo);
      write_limit(tfd_pkg::REG_FWD_HIGH, hi);
      write_limit(tfd_pkg::REG_SIDE_LIM, side);
      write_limit(tfd_pkg::REG_FALL_LIM, fall);
      write_limit(tfd_pkg::REG_COUNT_LIM, count);
      if ($urandom_range(2) == 0) write_limit(UnusedReg + $urandom_range(0, 2), $urandom);
   endtask

   // Entered and left at a falling edge; valid stays high so that requests can follow
   // back to back.
   task automatic push_sample(input logic signed [tfd_pkg::AngleBits-1:0] a,
                              input logic signed [tfd_pkg::AngleBits-1:0] b);
      if (idle_on && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_angle_a <= a;
      req_angle_b <= b;
      do @(posedge clock); while (!req_ready);
      book.note_request(a, b);
      @(negedge clock);
   endtask

   task automatic run_sequence(input run_kind_type kind, input int length);
      logic signed [tfd_pkg::AngleBits-1:0] a, b;
      for (int i = 0; i < length; i++) begin
         make_angles(kind, a, b);
         push_sample(a, b);
      end
      random_count += length;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      run_kind_type kind;
      int           length;
      int           target;
      book = new();
      idle_on = 1'b0;
      random_count = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_angle_a = '0;
      req_angle_b = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_sample(0, 0);
      push_sample(0, 80);
      push_sample(0, 81);
      push_sample(0, -400);
      push_sample(0, -401);
      push_sample(448, 0);
      push_sample(-448, 0);
      push_sample(449, 0);
      push_sample(-449, 0);
      push_sample(0, -960);
      push_sample(0, -961);
      push_sample(0, 961);
      push_sample(961, 0);
      push_sample(-961, 0);
      push_sample(-4096, -4096);
      push_sample(4095, 4095);
      push_sample(-4096, 4095);
      push_sample(4095, -4096);
      push_sample(2880, -2880);
      push_sample(-2880, 2880);
      settle();

      for (int phase = 0; random_count < RandomItems; phase++) begin
         idle_on = (random_count < RandomItems - CalmItems);
         case (phase)
            0: ;
            1: set_limits(-2880, 2880, 2880, 0, 0);
            2: set_limits(0, 0, 0, 2880, 254);
            3: set_limits(100, -100, 448, 960, 255);
            4: begin
               set_limits(-80, 400, 448, 960, 2);
               run_sequence(RUN_SAFE, 270);
               run_sequence(RUN_BACK, 265);
            end
            default: begin
               if ($urandom_range(4) == 0)
                  set_limits($urandom, $urandom, $urandom, $urandom, $urandom);
               else
                  set_limits(pick(-2880, 400), pick(-200, 2880), pick(0, 2880), pick(0, 2880),
                             ($urandom_range(5) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 16));
            end
         endcase
         target = random_count + PhaseItems;
         while (random_count < target) begin
            idle_on = (random_count < RandomItems - CalmItems) && ($urandom_range(3) != 0);
            kind = run_kind_type'($urandom_range(int'(RUN_SAFE), int'(RUN_BROKEN)));
            if ($urandom_range(3) == 0) kind = RUN_SAFE;
            length = $urandom_range(1, 24);
            if ($urandom_range(7) == 0) length = int'(book.count_lim) + $urandom_range(1, 4);
            run_sequence(kind, length);
         end
         settle();
      end

      idle_on = 1'b0;
      repeat (10) @(posedge clock);
      if (book.mismatches == 0 && book.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: tilt_fall_detector.f
+incdir+hdl
hdl/tfd_pkg.sv
hdl/tfd_front.sv
hdl/tfd_queue.sv
hdl/tfd_back.sv
hdl/tilt_fall_detector.sv
hdl/tfd_checker.sv
tb/sv/tb_top.sv
